// File: rtl/core/jase_pkg.sv
// Package for the JSON array string extractor.
// Character codes, result kinds, register indexes and shared types.
// No dependencies.
package jase_pkg;

   localparam int KEY_MAX_BYTES_DEFAULT = 8;
   localparam int MAX_ELEMENTS_DEFAULT  = 65535;

   localparam int BYTE_W   = 8;
   localparam int KEY_W    = 64;
   localparam int LEN_W    = 4;
   localparam int NUM_W    = 16;
   localparam int KIND_W   = 2;
   localparam int CSR_IDX_W = 2;

   // Characters of interest
   localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_RBRACKET = 8'h5D;
   localparam logic [BYTE_W-1:0] CH_COMMA    = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_COLON    = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
   localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_QUOTE    = 8'h22;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_CONTENT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ELEM_END = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FINISHED = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH = 2'd1;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data_byte;
      logic [NUM_W-1:0]  element_number;
      logic              run_last;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } win_ctrl_type;

endpackage

// File: rtl/core/jase_if.sv
// Stream interfaces for the request and response channels.
// Depends on jase_pkg for field widths.
interface jase_req_if;
   logic                        valid;
   logic                        ready;
   logic [jase_pkg::BYTE_W-1:0] in_byte;
   logic                        is_last;

   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface jase_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [jase_pkg::KIND_W-1:0] kind;
   logic [jase_pkg::BYTE_W-1:0] data_byte;
   logic [jase_pkg::NUM_W-1:0]  element_number;
   logic                        run_last;

   modport source (output valid, output kind, output data_byte, output element_number,
                   output run_last, input ready);
   modport sink (input valid, input kind, input data_byte, input element_number,
                 input run_last, output ready);
endinterface

// File: rtl/core/jase_cell.sv
// One cell of the key search window: holds a byte, compares it to its key byte.
// Depends on jase_pkg.
module jase_cell (
   input  logic                        clock,
   input  logic                        shift_en,
   input  logic [jase_pkg::BYTE_W-1:0] prev_byte,
   input  logic [jase_pkg::BYTE_W-1:0] expected,
   input  logic                        care,
   output logic [jase_pkg::BYTE_W-1:0] byte_q,
   output logic                        hit
);

   logic [jase_pkg::BYTE_W-1:0] byte_ff;
   logic [jase_pkg::BYTE_W-1:0] byte_in;

   assign byte_in = shift_en ? prev_byte : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign byte_q = byte_ff;
   assign hit    = !care || (byte_ff == expected);

endmodule

// File: rtl/core/jase_key_window.sv
// Row of window cells plus fill count; flags a quoted key ending on the current byte.
// Depends on jase_pkg and jase_cell.
module jase_key_window #(
   parameter int KEY_MAX_BYTES = jase_pkg::KEY_MAX_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  jase_pkg::win_ctrl_type        ctrl,
   input  logic [jase_pkg::BYTE_W-1:0]   in_byte,
   input  logic [jase_pkg::KEY_W-1:0]    key_word,
   input  logic [jase_pkg::LEN_W-1:0]    key_length,
   output logic                          match
);

   localparam int DEPTH  = KEY_MAX_BYTES + 1;
   localparam int SEEN_W = $clog2(DEPTH + 1);
   localparam int CMP_W  = jase_pkg::LEN_W + 1;
   localparam int KIDX_W = $clog2(jase_pkg::KEY_W / jase_pkg::BYTE_W);

   logic [SEEN_W-1:0]            seen_ff;
   logic [SEEN_W-1:0]            seen_in;
   logic [jase_pkg::LEN_W-1:0]   len_eff;
   logic [jase_pkg::BYTE_W-1:0]  cell_byte [DEPTH];
   logic [DEPTH-1:0]             cell_hit;
   logic                         enough;

   // lengths past the window size count as the full window
   assign len_eff = (key_length > jase_pkg::LEN_W'(KEY_MAX_BYTES)) ?
                    jase_pkg::LEN_W'(KEY_MAX_BYTES) : key_length;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [jase_pkg::BYTE_W-1:0] prev;
      logic [jase_pkg::BYTE_W-1:0] expected;
      logic [KIDX_W-1:0]           kidx;
      logic                        care;

      if (i == 0) begin : g_head
         assign prev = in_byte;
      end else begin : g_body
         assign prev = cell_byte[i-1];
      end

      // cell i holds key byte len-1-i, the cell at len holds the opening quote
      assign kidx     = KIDX_W'(len_eff - jase_pkg::LEN_W'(i) - jase_pkg::LEN_W'(1));
      assign care     = jase_pkg::LEN_W'(i) <= len_eff;
      assign expected = (jase_pkg::LEN_W'(i) == len_eff) ? jase_pkg::CH_QUOTE :
                        key_word[{kidx, 3'b000} +: jase_pkg::BYTE_W];

      jase_cell u_cell (
         .clock     (clock),
         .shift_en  (ctrl.shift),
         .prev_byte (prev),
         .expected  (expected),
         .care      (care),
         .byte_q    (cell_byte[i]),
         .hit       (cell_hit[i])
      );
   end

   always_comb begin
      seen_in = seen_ff;
      if (ctrl.clear) begin
         seen_in = '0;
      end else if (ctrl.shift && (seen_ff < SEEN_W'(DEPTH))) begin
         seen_in = seen_ff + SEEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   assign enough = CMP_W'(seen_ff) >= (CMP_W'(len_eff) + CMP_W'(1));
   assign match  = (in_byte == jase_pkg::CH_QUOTE) && enough && (&cell_hit);

endmodule

// File: rtl/core/json_array_string_extractor_unit.sv
// Top level of the JSON array string extractor.
// Depends on jase_pkg, jase_if (jase_req_if, jase_rsp_if) and jase_key_window.
//
//  channel   dir  handshake               payload
//  req_chan  in   valid/ready             in_byte, is_last
//  rsp_chan  out  valid/ready             kind, data_byte, element_number, run_last
//  csr_*     in   csr_write_enable only   csr_index, csr_write_data
//
// One request per cycle while each request yields at most one response and the
// response side is not stalled; a request that yields more responses holds the
// request side while the single response register drains the per-request result
// bundle. Responses pass through the bundle and then the output register.
// Reset is synchronous and clears phase, counts, keys and valid flags.
// A stalled response side backs up into the bundle and then into req ready.
module json_array_string_extractor_unit #(
   parameter int KEY_MAX_BYTES = jase_pkg::KEY_MAX_BYTES_DEFAULT,
   parameter int MAX_ELEMENTS  = jase_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   jase_req_if.sink                         req_chan,
   jase_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [jase_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [jase_pkg::KEY_W-1:0]       csr_write_data
);

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_AFTER_KEY,
      PH_ARRAY,
      PH_STRING,
      PH_SKIP,
      PH_DONE
   } phase_type;

   phase_type                       phase_ff, phase_in, phase_step;
   logic [jase_pkg::NUM_W-1:0]      count_ff, count_in, count_step;
   logic [jase_pkg::KEY_W-1:0]      key_word_ff, key_word_in;
   logic [jase_pkg::LEN_W-1:0]      key_length_ff, key_length_in;

   // bundle of results from one request, drained from slot 0
   jase_pkg::rsp_type               bun_ff [3];
   jase_pkg::rsp_type               bun_in [3];
   logic [1:0]                      bun_cnt_ff, bun_cnt_in;

   jase_pkg::rsp_type               rsp_ff, rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   jase_pkg::win_ctrl_type          win_ctrl;
   logic                            match;
   logic                            out_free, bun_pop, accept;
   logic [jase_pkg::BYTE_W-1:0]     b;
   logic                            last, is_ws;

   jase_pkg::rsp_type               r_main, r_unterm, r_fin;
   logic                            m_valid, u_valid;
   jase_pkg::rsp_type               list [3];
   logic [1:0]                      list_cnt;

   assign b    = req_chan.in_byte;
   assign last = req_chan.is_last;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign bun_pop  = (bun_cnt_ff != 2'd0) && out_free;
   // take a request once the bundle is empty or empties this cycle
   assign req_chan.ready = (bun_cnt_ff == 2'd0) || ((bun_cnt_ff == 2'd1) && out_free);
   assign accept = req_chan.valid && req_chan.ready;

   assign is_ws = (b == jase_pkg::CH_SPACE) || (b == jase_pkg::CH_TAB) ||
                  (b == jase_pkg::CH_LF) || (b == jase_pkg::CH_CR);

   jase_key_window #(
      .KEY_MAX_BYTES (KEY_MAX_BYTES)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (win_ctrl),
      .in_byte    (b),
      .key_word   (key_word_ff),
      .key_length (key_length_ff),
      .match      (match)
   );

   // phase step for the byte on offer
   always_comb begin
      phase_step = phase_ff;
      count_step = count_ff;
      m_valid    = 1'b0;
      r_main     = '0;
      unique case (phase_ff)
         PH_SEARCH: begin
            if (match) begin
               phase_step = PH_AFTER_KEY;
            end
         end
         PH_AFTER_KEY: begin
            if (!(is_ws || (b == jase_pkg::CH_COLON))) begin
               phase_step = (b == jase_pkg::CH_LBRACKET) ? PH_ARRAY : PH_DONE;
            end
         end
         PH_ARRAY: begin
            if (is_ws || (b == jase_pkg::CH_COMMA)) begin
               phase_step = PH_ARRAY;
            end else if (b == jase_pkg::CH_RBRACKET) begin
               phase_step = PH_DONE;
            end else if (b == jase_pkg::CH_QUOTE) begin
               if (count_ff < jase_pkg::NUM_W'(MAX_ELEMENTS)) begin
                  count_step = count_ff + jase_pkg::NUM_W'(1);
               end
               phase_step = PH_STRING;
            end else begin
               phase_step = PH_SKIP;
            end
         end
         PH_STRING: begin
            m_valid               = 1'b1;
            r_main.element_number = count_ff;
            if (b == jase_pkg::CH_QUOTE) begin
               r_main.kind = jase_pkg::KIND_ELEM_END;
               phase_step  = PH_ARRAY;
            end else begin
               r_main.kind      = jase_pkg::KIND_CONTENT;
               r_main.data_byte = b;
            end
         end
         PH_SKIP: begin
            if (b == jase_pkg::CH_COMMA) begin
               phase_step = PH_ARRAY;
            end else if (b == jase_pkg::CH_RBRACKET) begin
               phase_step = PH_DONE;
            end
         end
         PH_DONE: begin
            phase_step = PH_DONE;
         end
         default: begin
            phase_step = PH_DONE;
         end
      endcase
      r_main.run_last = !last;

      // string left open at end of text is closed before the finish
      u_valid                 = last && (phase_step == PH_STRING);
      r_unterm                = '0;
      r_unterm.kind           = jase_pkg::KIND_ELEM_END;
      r_unterm.element_number = count_step;

      r_fin                   = '0;
      r_fin.kind              = jase_pkg::KIND_FINISHED;
      r_fin.element_number    = count_step;
      r_fin.run_last          = 1'b1;
   end

   // pack results into bundle order
   always_comb begin
      list[0]  = m_valid ? r_main : (u_valid ? r_unterm : r_fin);
      list[1]  = m_valid ? (u_valid ? r_unterm : r_fin) : r_fin;
      list[2]  = r_fin;
      list_cnt = 2'(m_valid) + 2'(u_valid) + 2'(last);
   end

   assign win_ctrl.shift = accept && (phase_ff == PH_SEARCH) && !match;
   assign win_ctrl.clear = accept && last;

   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      key_word_in   = key_word_ff;
      key_length_in = key_length_ff;
      bun_in        = bun_ff;
      bun_cnt_in    = bun_cnt_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (accept) begin
         phase_in = last ? PH_SEARCH : phase_step;
         count_in = last ? '0 : count_step;
      end

      if (csr_write_enable) begin
         unique case (csr_index)
            jase_pkg::CSR_KEY_WORD:   key_word_in   = csr_write_data;
            jase_pkg::CSR_KEY_LENGTH: key_length_in = csr_write_data[jase_pkg::LEN_W-1:0];
            default: ;
         endcase
      end

      if (out_free) begin
         rsp_valid_in = bun_cnt_ff != 2'd0;
         rsp_in       = bun_ff[0];
      end

      if (accept) begin
         bun_in     = list;
         bun_cnt_in = list_cnt;
      end else if (bun_pop) begin
         bun_in[0]  = bun_ff[1];
         bun_in[1]  = bun_ff[2];
         bun_cnt_in = bun_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SEARCH;
         count_ff      <= '0;
         key_word_ff   <= '0;
         key_length_ff <= '0;
         bun_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         key_word_ff   <= key_word_in;
         key_length_ff <= key_length_in;
         bun_cnt_ff    <= bun_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      bun_ff <= bun_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.kind           = rsp_ff.kind;
   assign rsp_chan.data_byte      = rsp_ff.data_byte;
   assign rsp_chan.element_number = rsp_ff.element_number;
   assign rsp_chan.run_last       = rsp_ff.run_last;

endmodule
